FILE: sv/etl_pkg.sv
package etl_pkg;

  // Default sizing of the lexer.
  localparam int MANTISSA_BITS_DEFAULT       = 32;
  localparam int MAX_WORD_LETTERS_DEFAULT    = 9;
  localparam int MAX_FRACTION_DIGITS_DEFAULT = 15;

  // Fixed field widths of a token.
  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 3;
  localparam int OP_W       = 3;
  localparam int FUNC_W     = 2;
  localparam int MANT_OUT_W = 32;
  localparam int FRAC_W     = 4;
  localparam int WLEN_W     = 4;

  // Token kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER   = 3'd0,
    KIND_OPERATOR = 3'd1,
    KIND_VARIABLE = 3'd2,
    KIND_FUNCTION = 3'd3,
    KIND_OPEN     = 3'd4,
    KIND_CLOSE    = 3'd5,
    KIND_ERROR    = 3'd6,
    KIND_END      = 3'd7
  } kind_t;

  // Operator codes.
  localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
  localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
  localparam logic [OP_W-1:0] OP_POWER  = 3'd4;

  // Function names in upper case, in function code order.
  localparam int NUM_FUNCS = 4;
  localparam logic [23:0] FUNC_NAMES [NUM_FUNCS] = '{"SIN", "COS", "TAN", "EXP"};

  // Setting this mask on an upper-case name gives its lower-case spelling.
  localparam logic [23:0] LOWER_MASK = 24'h202020;

  // One output token.
  typedef struct packed {
    kind_t                  kind;
    logic [OP_W-1:0]        op;
    logic [FUNC_W-1:0]      func;
    logic [MANT_OUT_W-1:0]  mant;
    logic [FRAC_W-1:0]      frac;
    logic                   ovf;
    logic                   last;
  } token_t;

endpackage

FILE: sv/expression_token_lexer.sv
// Expression token lexer: takes one ASCII character per transaction and
// returns tokens (numbers, operators, x, sin/cos/tan/exp, parentheses, errors
// and an end token on character 0). A character is taken in every cycle and
// its tokens go to the queue; tokens leave at one per cycle while token_ready
// is high. A character that closes a number or word yields two tokens, and a
// four-entry token queue absorbs them: character_ready is high while at
// least two queue entries are free. With token_ready held high the queue
// never holds more than two tokens, so a character is taken in every cycle;
// only a stalled token port can fill the queue and drop character_ready.
module expression_token_lexer #(
  parameter int MANTISSA_BITS       = etl_pkg::MANTISSA_BITS_DEFAULT,
  parameter int MAX_WORD_LETTERS    = etl_pkg::MAX_WORD_LETTERS_DEFAULT,
  parameter int MAX_FRACTION_DIGITS = etl_pkg::MAX_FRACTION_DIGITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [etl_pkg::CHAR_W-1:0]        character,
  input  logic                              character_valid,
  output logic                              character_ready,
  output logic [etl_pkg::KIND_W-1:0]        token_kind,
  output logic [etl_pkg::OP_W-1:0]          operator_code,
  output logic [etl_pkg::FUNC_W-1:0]        function_code,
  output logic [etl_pkg::MANT_OUT_W-1:0]    mantissa,
  output logic [etl_pkg::FRAC_W-1:0]        fraction_digits,
  output logic                              overflow,
  output logic                              last,
  output logic                              token_valid,
  input  logic                              token_ready
);
  import etl_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int PROD_W = MANTISSA_BITS + 4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD
  } mode_t;

  // Scan state.
  mode_t                     scan_mode, scan_mode_next;
  logic [MANTISSA_BITS-1:0]  number_value, number_value_next;
  logic [FRAC_W-1:0]         fraction_count, fraction_count_next;
  logic                      dot_seen, dot_seen_next;
  logic                      second_dot_seen, second_dot_seen_next;
  logic                      value_saturated, value_saturated_next;
  logic [WLEN_W-1:0]         word_length, word_length_next;
  logic [CHAR_W-1:0]         word_letters [3];

  // Token queue.
  token_t                    queue_mem [QDEPTH];
  logic [QPTR_W-1:0]         wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]         count;

  logic                      accept, pop;
  logic                      is_digit, is_dot, is_num, is_letter, is_space;
  logic                      run_num, start_num, run_word, start_word, go_idle;
  logic                      flush_v, tok_v;
  token_t                    flush_tok, tok, word_tok, push0_tok;
  logic [1:0]                push_n;

  // Number datapath signals.
  logic [MANTISSA_BITS-1:0]  nb_val;
  logic [FRAC_W-1:0]         nb_frac;
  logic                      nb_dot, nb_dot2, nb_sat;
  logic [PROD_W-1:0]         nb_prod;
  logic [3:0]                digit;

  // Word datapath signals.
  logic [WLEN_W-1:0]         wb_idx;
  logic                      letter_we;
  logic                      func_hit;
  logic [FUNC_W-1:0]         func_code;

  assign accept          = character_valid && character_ready;
  assign character_ready = (count <= QCNT_W'(QDEPTH - 2));
  assign token_valid     = (count != '0);
  assign pop             = token_valid && token_ready;

  // Character classes.
  assign is_digit  = (character >= "0") && (character <= "9");
  assign is_dot    = (character == ".");
  assign is_num    = is_digit || is_dot;
  assign is_letter = ((character >= "A") && (character <= "Z")) ||
                     ((character >= "a") && (character <= "z"));
  assign is_space  = (character == " ") || ((character >= 8'd9) && (character <= 8'd13));
  assign digit     = character[3:0];

  // Function name match on a word of exactly three letters.
  always_comb begin
    func_hit  = 1'b0;
    func_code = '0;
    for (int f = 0; f < NUM_FUNCS; f++) begin
      if (!func_hit && (word_length == WLEN_W'(3)) &&
          (({word_letters[0], word_letters[1], word_letters[2]} == FUNC_NAMES[f]) ||
           ({word_letters[0], word_letters[1], word_letters[2]} ==
            (FUNC_NAMES[f] | LOWER_MASK)))) begin
        func_hit  = 1'b1;
        func_code = FUNC_W'(f);
      end
    end
  end

  always_comb begin
    word_tok = '0;
    if (func_hit) begin
      word_tok.kind = KIND_FUNCTION;
      word_tok.func = func_code;
    end else begin
      word_tok.kind = KIND_ERROR;
    end
  end

  // Decide what this character does: extend a run, close it, start one.
  always_comb begin
    scan_mode_next = scan_mode;
    run_num    = 1'b0;
    start_num  = 1'b0;
    run_word   = 1'b0;
    start_word = 1'b0;
    go_idle    = 1'b0;
    flush_v    = 1'b0;
    flush_tok  = '0;
    tok_v      = 1'b0;
    tok        = '0;
    if (accept) begin
      unique case (scan_mode)
        MODE_NUMBER: begin
          if (is_num) begin
            run_num = 1'b1;
          end else begin
            flush_v        = 1'b1;
            flush_tok.kind = KIND_NUMBER;
            flush_tok.mant = MANT_OUT_W'(number_value);
            flush_tok.frac = fraction_count;
            flush_tok.ovf  = value_saturated;
            go_idle        = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_letter && (word_length < WLEN_W'(MAX_WORD_LETTERS))) begin
            run_word = 1'b1;
          end else begin
            flush_v   = 1'b1;
            flush_tok = word_tok;
            go_idle   = 1'b1;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      if (go_idle) begin
        scan_mode_next = MODE_IDLE;
        if (character == 8'd0) begin
          tok_v     = 1'b1;
          tok.kind  = KIND_END;
          tok.last  = 1'b1;
        end else if (!is_space) begin
          tok_v = 1'b1;
          unique case (character)
            "(": tok.kind = KIND_OPEN;
            ")": tok.kind = KIND_CLOSE;
            "+": begin tok.kind = KIND_OPERATOR; tok.op = OP_PLUS;   end
            "-": begin tok.kind = KIND_OPERATOR; tok.op = OP_MINUS;  end
            "*": begin tok.kind = KIND_OPERATOR; tok.op = OP_TIMES;  end
            "/": begin tok.kind = KIND_OPERATOR; tok.op = OP_DIVIDE; end
            "^": begin tok.kind = KIND_OPERATOR; tok.op = OP_POWER;  end
            "x", "X": tok.kind = KIND_VARIABLE;
            default: begin
              if (is_num) begin
                tok_v          = 1'b0;
                start_num      = 1'b1;
                scan_mode_next = MODE_NUMBER;
              end else if (is_letter) begin
                tok_v          = 1'b0;
                start_word     = 1'b1;
                scan_mode_next = MODE_WORD;
              end else begin
                tok.kind = KIND_ERROR;
              end
            end
          endcase
        end
      end
    end
  end

  // Number run: one digit is a multiply by ten plus the digit, with saturation.
  always_comb begin
    nb_val  = start_num ? '0   : number_value;
    nb_frac = start_num ? '0   : fraction_count;
    nb_dot  = start_num ? 1'b0 : dot_seen;
    nb_dot2 = start_num ? 1'b0 : second_dot_seen;
    nb_sat  = start_num ? 1'b0 : value_saturated;
    nb_prod = PROD_W'({nb_val, 3'b000}) + PROD_W'({nb_val, 1'b0}) + PROD_W'(digit);

    number_value_next    = number_value;
    fraction_count_next  = fraction_count;
    dot_seen_next        = dot_seen;
    second_dot_seen_next = second_dot_seen;
    value_saturated_next = value_saturated;
    if (run_num || start_num) begin
      number_value_next    = nb_val;
      fraction_count_next  = nb_frac;
      dot_seen_next        = nb_dot;
      second_dot_seen_next = nb_dot2;
      value_saturated_next = nb_sat;
      if (is_dot) begin
        if (nb_dot) begin
          second_dot_seen_next = 1'b1;
        end else begin
          dot_seen_next = 1'b1;
        end
      end else if (nb_dot2 || nb_sat) begin
        // Digits after a second dot or after saturation are ignored.
      end else if (nb_dot && (nb_frac >= FRAC_W'(MAX_FRACTION_DIGITS))) begin
        // Fraction digits past the limit are dropped.
      end else if (nb_prod[PROD_W-1:MANTISSA_BITS] != '0) begin
        number_value_next    = '1;
        value_saturated_next = 1'b1;
      end else begin
        number_value_next = nb_prod[MANTISSA_BITS-1:0];
        if (nb_dot) begin
          fraction_count_next = nb_frac + FRAC_W'(1);
        end
      end
    end
  end

  // Word run: keep the first three letters and count all of them.
  always_comb begin
    wb_idx           = start_word ? '0 : word_length;
    word_length_next = word_length;
    letter_we        = 1'b0;
    if (run_word || start_word) begin
      word_length_next = wb_idx + WLEN_W'(1);
      letter_we        = (wb_idx < WLEN_W'(3));
    end
  end

  // Queue push: a closed run's token goes first, then the character's token.
  always_comb begin
    push_n    = 2'(flush_v) + 2'(tok_v);
    push0_tok = flush_v ? flush_tok : tok;
  end

  // Scan state and queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_IDLE;
      number_value    <= '0;
      fraction_count  <= '0;
      dot_seen        <= 1'b0;
      second_dot_seen <= 1'b0;
      value_saturated <= 1'b0;
      word_length     <= '0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      scan_mode       <= scan_mode_next;
      number_value    <= number_value_next;
      fraction_count  <= fraction_count_next;
      dot_seen        <= dot_seen_next;
      second_dot_seen <= second_dot_seen_next;
      value_saturated <= value_saturated_next;
      word_length     <= word_length_next;
      wr_ptr          <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  // Letter store and queue entries hold payload only.
  always_ff @(posedge clk) begin
    if (letter_we) begin
      word_letters[wb_idx[1:0]] <= character;
    end
    if (push_n != 2'd0) begin
      queue_mem[wr_ptr] <= push0_tok;
    end
    if (push_n == 2'd2) begin
      queue_mem[wr_ptr + QPTR_W'(1)] <= tok;
    end
  end

  // Head of the queue drives the token port.
  assign token_kind      = queue_mem[rd_ptr].kind;
  assign operator_code   = queue_mem[rd_ptr].op;
  assign function_code   = queue_mem[rd_ptr].func;
  assign mantissa        = queue_mem[rd_ptr].mant;
  assign fraction_digits = queue_mem[rd_ptr].frac;
  assign overflow        = queue_mem[rd_ptr].ovf;
  assign last            = queue_mem[rd_ptr].last;

endmodule

FILE: tb/expression_token_lexer_test.sv
module expression_token_lexer_test;
  import etl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int FRAC_LIMIT   = MAX_FRACTION_DIGITS_DEFAULT;
  localparam int WORD_LIMIT   = MAX_WORD_LETTERS_DEFAULT;

  // Scan states of the lexer being predicted.
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD
  } scan_state_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [CHAR_W-1:0]     character = '0;
  logic                  character_valid = 1'b0;
  logic                  character_ready;
  logic [KIND_W-1:0]     token_kind;
  logic [OP_W-1:0]       operator_code;
  logic [FUNC_W-1:0]     function_code;
  logic [MANT_OUT_W-1:0] mantissa;
  logic [FRAC_W-1:0]     fraction_digits;
  logic                  overflow;
  logic                  last;
  logic                  token_valid;
  logic                  token_ready = 1'b0;

  // Characters waiting to be offered, and tokens the lexer still owes.
  logic [CHAR_W-1:0] pending_chars [$];
  token_t            expected_tokens [$];

  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  logic receiver_hold      = 1'b0;
  int   mismatch_count     = 0;
  int   cycle_count        = 0;

  // Predicted lexer state.
  scan_state_t      scan_state = SCAN_IDLE;
  logic [31:0]      num_value  = '0;
  logic [3:0]       frac_count = '0;
  logic             dot_seen   = 1'b0;
  logic             dot2_seen  = 1'b0;
  logic             saturated  = 1'b0;
  logic [7:0]       word_head [3] = '{8'd0, 8'd0, 8'd0};
  logic [3:0]       word_len   = '0;

  expression_token_lexer i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Folds one character into the number being scanned.
  task automatic number_char(logic [7:0] c);
    logic [63:0] grown;
    if (c == ".") begin
      if (dot_seen) dot2_seen = 1'b1;
      else dot_seen = 1'b1;
      return;
    end
    if (dot2_seen || saturated) return;
    if (dot_seen && frac_count >= FRAC_LIMIT) return;
    grown = 64'(num_value) * 64'd10 + 64'(c - 8'd48);
    if (grown > 64'h0000_0000_FFFF_FFFF) begin
      num_value = '1;
      saturated = 1'b1;
      return;
    end
    num_value = grown[31:0];
    if (dot_seen) frac_count = frac_count + 4'd1;
  endtask

  task automatic word_char(logic [7:0] c);
    if (word_len < 4'd3) word_head[word_len[1:0]] = c;
    word_len = word_len + 4'd1;
  endtask

  // Works out the tokens that one accepted character produces.
  task automatic lex_character(logic [7:0] c);
    token_t tok;
    logic [23:0] head;
    tok = '0;
    if (scan_state == SCAN_NUMBER) begin
      if (is_digit(c) || c == ".") begin
        number_char(c);
        return;
      end
      tok.kind = KIND_NUMBER;
      tok.mant = num_value;
      tok.frac = frac_count;
      tok.ovf  = saturated;
      expected_tokens.push_back(tok);
    end else if (scan_state == SCAN_WORD) begin
      if (is_letter(c) && word_len < WORD_LIMIT) begin
        word_char(c);
        return;
      end
      tok.kind = KIND_ERROR;
      head = {word_head[0], word_head[1], word_head[2]};
      if (word_len == 4'd3) begin
        for (int f = NUM_FUNCS - 1; f >= 0; f--) begin
          if (head == FUNC_NAMES[f] || head == (FUNC_NAMES[f] | LOWER_MASK)) begin
            tok.kind = KIND_FUNCTION;
            tok.func = FUNC_W'(f);
          end
        end
      end
      expected_tokens.push_back(tok);
    end
    scan_state = SCAN_IDLE;
    tok = '0;

    // A character handled on its own.
    case (c)
      8'd0: begin
        tok.kind = KIND_END;
        tok.last = 1'b1;
      end
      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, " ": return;
      "(": tok.kind = KIND_OPEN;
      ")": tok.kind = KIND_CLOSE;
      "+": begin
        tok.kind = KIND_OPERATOR;
        tok.op   = OP_PLUS;
      end
      "-": begin
        tok.kind = KIND_OPERATOR;
        tok.op   = OP_MINUS;
      end
      "*": begin
        tok.kind = KIND_OPERATOR;
        tok.op   = OP_TIMES;
      end
      "/": begin
        tok.kind = KIND_OPERATOR;
        tok.op   = OP_DIVIDE;
      end
      "^": begin
        tok.kind = KIND_OPERATOR;
        tok.op   = OP_POWER;
      end
      "x", "X": tok.kind = KIND_VARIABLE;
      default: begin
        if (is_digit(c) || c == ".") begin
          scan_state = SCAN_NUMBER;
          num_value  = '0;
          frac_count = '0;
          dot_seen   = 1'b0;
          dot2_seen  = 1'b0;
          saturated  = 1'b0;
          number_char(c);
          return;
        end
        if (is_letter(c)) begin
          scan_state = SCAN_WORD;
          word_len   = '0;
          word_char(c);
          return;
        end
        tok.kind = KIND_ERROR;
      end
    endcase
    expected_tokens.push_back(tok);
  endtask

  // Driver: offers pending characters and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      character_valid <= 1'b0;
    end else begin
      if (character_valid && character_ready) lex_character(character);
      if (!character_valid || character_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          character       <= pending_chars.pop_front();
          character_valid <= 1'b1;
        end else begin
          character_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks each accepted token against the oldest expectation.
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      token_ready <= 1'b0;
    end else begin
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: token expected none actual kind %0d", $time, token_kind);
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          report_field("token_kind", 32'(want.kind), 32'(token_kind));
          report_field("operator_code", 32'(want.op), 32'(operator_code));
          report_field("function_code", 32'(want.func), 32'(function_code));
          report_field("mantissa", want.mant, mantissa);
          report_field("fraction_digits", 32'(want.frac), 32'(fraction_digits));
          report_field("overflow", 32'(want.ovf), 32'(overflow));
          report_field("last", 32'(want.last), 32'(last));
        end
      end
      token_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL expression_token_lexer");
      $finish;
    end
  end

  task automatic add_char(logic [7:0] c);
    pending_chars.push_back(c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_digits(int count);
    repeat (count) add_char(8'(8'd48 + $urandom_range(9)));
  endtask

  function automatic logic [7:0] random_letter();
    return 8'(($urandom_range(1) ? 8'd65 : 8'd97) + $urandom_range(25));
  endfunction

  // Appends one random expression, mostly well formed, usually ended by 0.
  task automatic add_expression();
    string fn_names [4] = '{"SIN", "COS", "TAN", "EXP"};
    string op_chars = "+-*/^";
    int pick;
    int mode;
    int ws;
    string name;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            add_digits($urandom_range(1, 4));
            if ($urandom_range(1)) begin
              add_char(".");
              add_digits($urandom_range(0, 4));
            end
          end
          // Long integers can saturate the mantissa.
          5: add_digits($urandom_range(9, 13));
          // Long fractions can run past the digit limit.
          6: begin
            add_digits($urandom_range(1, 3));
            add_char(".");
            add_digits($urandom_range(13, 19));
          end
          // A second dot stops the digits from counting.
          7: begin
            add_digits($urandom_range(0, 3));
            add_char(".");
            add_digits($urandom_range(0, 3));
            add_char(".");
            add_digits($urandom_range(1, 3));
            if ($urandom_range(1)) add_char(".");
          end
          8: begin
            add_char(".");
            add_digits($urandom_range(0, 2));
          end
          // Values right around the mantissa limit.
          default: begin
            add_text("429496729");
            add_digits($urandom_range(1, 2));
          end
        endcase
      end else if (pick < 45) begin
        mode = $urandom_range(3);
        if (mode <= 1) begin
          name = fn_names[$urandom_range(3)];
          mode = $urandom_range(2);
          for (int k = 0; k < 3; k++) begin
            if (mode == 0) add_char(name[k]);
            else if (mode == 1) add_char(name[k] | 8'h20);
            else add_char(name[k] | ($urandom_range(1) ? 8'h20 : 8'h00));
          end
        end else if (mode == 2) begin
          repeat ($urandom_range(1, 12)) add_char(random_letter());
        end else begin
          // A full-length word followed by the variable.
          repeat (WORD_LIMIT) add_char(random_letter());
          add_char($urandom_range(1) ? "x" : "X");
        end
      end else if (pick < 62) begin
        add_char(op_chars[$urandom_range(4)]);
      end else if (pick < 70) begin
        add_char($urandom_range(1) ? "(" : ")");
      end else if (pick < 78) begin
        add_char($urandom_range(1) ? "x" : "X");
      end else if (pick < 88) begin
        ws = $urandom_range(5);
        add_char(ws == 5 ? " " : 8'(9 + ws));
      end else begin
        add_char(8'($urandom_range(255)));
      end
      if ($urandom_range(3) == 0) add_char(" ");
    end
    if ($urandom_range(9) != 0) add_char(8'd0);
  endtask

  // Waits until every character is taken and every token has arrived.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_chars.size() != 0 || character_valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int sender_pct, int receiver_pct, int char_count);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    while (pending_chars.size() < char_count) add_expression();
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operator but minus, parentheses, an upper-case X, a lone dot,
    // a second dot, a function in each case, whitespace, a high code, end.
    add_text("(X+.)*cos/1.2.3^EXP\t");
    add_char(8'hff);
    add_char(8'd0);
    wait_idle();

    run_phase(0, 0, 130);
    run_phase(81, 0, 130);
    run_phase(0, 81, 130);
    run_phase(23, 23, 100);

    // The receiver holds off while characters keep coming, so the lexer fills.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    receiver_hold     <= 1'b1;
    while (pending_chars.size() < 60) add_expression();
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $display("%0t: tokens expected %0d actual 0", $time, expected_tokens.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS expression_token_lexer");
    end else begin
      $display("FAIL expression_token_lexer");
    end
    $finish;
  end

endmodule

FILE: expression_token_lexer.f
sv/etl_pkg.sv
sv/expression_token_lexer.sv
tb/expression_token_lexer_test.sv
